>>> design/dtq_pkg.sv
// deadline timer queue package: command codes and shared types
// no dependencies
package dtq_pkg;
	typedef enum logic [2:0] {
		CMD_SCHEDULE = 3'd0,
		CMD_CANCEL   = 3'd1,
		CMD_INTR     = 3'd2,
		CMD_BEGIN    = 3'd3,
		CMD_TAKE     = 3'd4,
		CMD_FINISH   = 3'd5,
		CMD_PENDING  = 3'd6,
		CMD_NONE     = 3'd7
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_LAST = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;
endpackage

>>> design/deadline_timer_queue_core.sv
// deadline timer queue top level: command decode, scan sequencer, flags
// depends on dtq_pkg and dtq_mem
//
// usage: drive command, timer_slot, deadline_time and now_time with start
// while busy is low; that cycle is the transfer. exactly one result follows,
// shown for one cycle with done high; the receiver cannot stall it.
// schedule, cancel, begin batch, finish and pending go from the transfer
// straight to the done state, which registers the result. interrupt and
// take next read every slot from the slot memory, one slot per cycle
// through its single read port, then pass the last and done states.
// busy is high after the transfer until the result: one command in flight.
// at reset all scheduled flags, the sequence counter, the running record and
// the batch registers clear; the memory needs no clearing since only
// scheduled slots are used.
module deadline_timer_queue_core import dtq_pkg::*; #(
	parameter int TIMER_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [5:0]  timer_slot,
	input  logic [63:0] deadline_time,
	input  logic [63:0] now_time,
	output logic        done,
	output logic        ok_flag,
	output logic [5:0]  result_slot,
	output logic [63:0] time_out,
	output logic        wake_flag
);
	localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = AW + 1;

	state_t        state_q;
	logic [2:0]    cmd_q;
	logic [5:0]    slot_q;
	logic [63:0]   dl_q, now_q;
	logic [TIMER_SLOTS-1:0] sched_q;
	logic [63:0]   seq_q, bnow_q, blim_q;
	logic          run_v_q;
	logic [AW-1:0] run_slot_q;
	logic [CW-1:0] ridx_q;
	logic [AW-1:0] cidx_s1;
	logic          cval_s1;
	logic          found_q, wake_q;
	logic [AW-1:0] best_q;
	logic [63:0]   best_dl_q, best_seq_q, next_q;
	logic          have_next_q;

	logic          we;
	logic [127:0]  rdata;
	logic [63:0]   r_dl, r_seq;
	logic          in_range;
	logic [AW-1:0] slot_a;

	assign in_range = {26'd0, slot_q} < 32'(TIMER_SLOTS);
	assign slot_a = AW'(slot_q);
	assign we = state_q == ST_DONE && cmd_q == CMD_SCHEDULE && in_range;
	assign r_dl = rdata[127:64];
	assign r_seq = rdata[63:0];

	dtq_mem #(.DEPTH(TIMER_SLOTS), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(slot_a), .wdata({dl_q, seq_q}),
		.raddr(ridx_q[AW-1:0]), .rdata(rdata)
	);

	assign busy = state_q != ST_IDLE;

	logic cand, better, due;
	always_comb begin
		due = r_dl <= now_q;
		cand = cval_s1 && sched_q[cidx_s1] && r_dl <= bnow_q && r_seq < blim_q;
		better = !found_q || r_dl < best_dl_q ||
			(r_dl == best_dl_q && r_seq < best_seq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sched_q <= '0;
			seq_q <= '0;
			bnow_q <= '0;
			blim_q <= '0;
			run_v_q <= 1'b0;
			run_slot_q <= '0;
			done <= 1'b0;
			cval_s1 <= 1'b0;
			ridx_q <= '0;
			cmd_q <= '0;
			slot_q <= '0;
			dl_q <= '0;
			now_q <= '0;
			cidx_s1 <= '0;
			found_q <= 1'b0;
			wake_q <= 1'b0;
			best_q <= '0;
			best_dl_q <= '0;
			best_seq_q <= '0;
			next_q <= '0;
			have_next_q <= 1'b0;
			ok_flag <= 1'b0;
			result_slot <= '0;
			time_out <= '0;
			wake_flag <= 1'b0;
		end else begin
			done <= 1'b0;
			cval_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q <= command;
						slot_q <= timer_slot;
						dl_q <= deadline_time;
						now_q <= now_time;
						ridx_q <= '0;
						found_q <= 1'b0;
						wake_q <= 1'b0;
						have_next_q <= 1'b0;
						best_q <= '0;
						if (command == CMD_INTR || command == CMD_TAKE)
							state_q <= ST_SCAN;
						else
							state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (ridx_q != CW'(TIMER_SLOTS)) begin
						cval_s1 <= 1'b1;
						cidx_s1 <= ridx_q[AW-1:0];
						ridx_q <= ridx_q + 1'b1;
					end else begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: state_q <= ST_DONE;
				ST_DONE: begin
					state_q <= ST_IDLE;
					done <= 1'b1;
					ok_flag <= 1'b0;
					result_slot <= '0;
					time_out <= '0;
					wake_flag <= 1'b0;
					case (cmd_q)
						CMD_SCHEDULE: begin
							if (in_range) begin
								sched_q[slot_a] <= 1'b1;
								seq_q <= seq_q + 1'b1;
								time_out <= dl_q;
							end
						end
						CMD_CANCEL: begin
							if (!in_range)
								ok_flag <= 1'b1;
							else if (!(run_v_q && run_slot_q == slot_a)) begin
								sched_q[slot_a] <= 1'b0;
								ok_flag <= 1'b1;
							end
						end
						CMD_INTR: begin
							wake_flag <= wake_q;
							time_out <= have_next_q ? next_q : '1;
						end
						CMD_BEGIN: begin
							bnow_q <= now_q;
							blim_q <= seq_q;
						end
						CMD_TAKE: begin
							if (found_q) begin
								sched_q[best_q] <= 1'b0;
								run_v_q <= 1'b1;
								run_slot_q <= best_q;
								ok_flag <= 1'b1;
								result_slot <= 6'(best_q);
							end
						end
						CMD_FINISH: run_v_q <= 1'b0;
						CMD_PENDING: ok_flag <= in_range && sched_q[slot_a];
						default: ;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cval_s1 && cmd_q == CMD_TAKE && cand && better) begin
				found_q <= 1'b1;
				best_q <= cidx_s1;
				best_dl_q <= r_dl;
				best_seq_q <= r_seq;
			end
			if (cval_s1 && cmd_q == CMD_INTR && sched_q[cidx_s1]) begin
				if (due)
					wake_q <= 1'b1;
				else if (!have_next_q || r_dl < next_q) begin
					next_q <= r_dl;
					have_next_q <= 1'b1;
				end
			end
		end
	end

	property p_busy_done;
		@(posedge clk) disable iff (!arst_n) done |-> busy == 1'b0;
	endproperty
	assert property (p_busy_done) else $error("busy during result");

	property p_start_busy;
		@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy;
	endproperty
	assert property (p_start_busy) else $error("no busy after transfer");

	property p_take_sched;
		@(posedge clk) disable iff (!arst_n)
			(done && ok_flag && $past(cmd_q) == CMD_TAKE) |-> run_v_q;
	endproperty
	assert property (p_take_sched) else $error("take without running");
endmodule

>>> design/dtq_mem.sv
// slot memory: deadline and sequence per slot, one write and one read port,
// registered read; depends on nothing
module dtq_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [127:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [127:0]  rdata
);
	logic [127:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
